// File: design/opf_pkg.sv
// ----------------------------------------------------------------------------
// opf_pkg - shared types and constants for the one-pole filter cascade
// Sequencer states, serial multiplier control and register indexes.
// ----------------------------------------------------------------------------
package opf_pkg;

	// Extra integrator bits above the sample width
	localparam int STATE_HEADROOM = 4;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_CUT_ENABLE  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_CUT_COEF    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_CUT_ENABLE = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_CUT_COEF   = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_MUL,
		ST_FIN1,
		ST_FIN2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctl_t;

endpackage

// File: design/opf_sermul.sv
// ----------------------------------------------------------------------------
// opf_sermul - serial-parallel shift-add multiplier
// Consumes one coefficient bit per cycle while ctl.step is high, LSB first;
// product bits shift out of the accumulator one per cycle. Result is
// floor(d * coef / 2^COEF_BITS) plus the last bit out, the round-half-up carry.
// ----------------------------------------------------------------------------
module opf_sermul #(
	parameter int DATA_BITS = 29,
	parameter int COEF_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  opf_pkg::mul_ctl_t           ctl,
	input  logic signed [DATA_BITS-1:0] d_in,
	input  logic        [COEF_BITS-1:0] coef_in,
	output logic signed [DATA_BITS-1:0] hi,
	output logic                        rnd,
	output logic                        last
);
	import opf_pkg::*;

	localparam int CNT_BITS = $clog2(COEF_BITS);

	logic signed [DATA_BITS-1:0] d_q;
	logic signed [DATA_BITS-1:0] acc_q;
	logic        [COEF_BITS-1:0] coef_q;
	logic        [CNT_BITS-1:0]  cnt_q;
	logic                        rnd_q;
	logic signed [DATA_BITS:0]   sum;

	always_comb begin
		sum = $signed({acc_q[DATA_BITS-1], acc_q})
			+ (coef_q[0] ? $signed({d_q[DATA_BITS-1], d_q}) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= CNT_BITS'(COEF_BITS - 1);
		end else if (ctl.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			d_q    <= d_in;
			coef_q <= coef_in;
			acc_q  <= '0;
			rnd_q  <= 1'b0;
		end else if (ctl.step) begin
			// drop one product bit, advance to the next coefficient bit
			acc_q  <= sum[DATA_BITS:1];
			rnd_q  <= sum[0];
			coef_q <= coef_q >> 1;
		end
	end

	assign hi   = acc_q;
	assign rnd  = rnd_q;
	assign last = (cnt_q == '0);

endmodule

// File: design/opf_tail.sv
// ----------------------------------------------------------------------------
// opf_tail - integrator update and output saturation of one section
// On capture, v and the low-pass value are registered; the new saturated
// state and the saturated section output are formed combinationally from them.
// ----------------------------------------------------------------------------
module opf_tail #(
	parameter int SAMPLE_BITS = 24,
	parameter int STATE_BITS  = 28,
	parameter int DATA_BITS   = 29
) (
	input  logic                          clk,
	input  logic                          capture,
	input  logic                          is_lowpass,
	input  logic signed [DATA_BITS-1:0]   hi,
	input  logic                          rnd,
	input  logic signed [STATE_BITS-1:0]  s,
	input  logic signed [SAMPLE_BITS-1:0] x,
	output logic signed [STATE_BITS-1:0]  state_next,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import opf_pkg::*;

	localparam int LW = DATA_BITS + 2;

	logic signed [LW-1:0] hi_ext;
	logic signed [LW-1:0] s_ext;
	logic signed [LW-1:0] x_ext;
	logic signed [LW-1:0] rnd_ext;
	logic signed [LW-1:0] v_q;
	logic signed [LW-1:0] low_q;
	logic signed [LW-1:0] st_sum;
	logic signed [LW-1:0] hp_diff;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [LW-1:0] a
	);
		logic same;
		same = (&a[LW-1:SAMPLE_BITS-1]) | ~(|a[LW-1:SAMPLE_BITS-1]);
		if (same) begin
			return a[SAMPLE_BITS-1:0];
		end
		return {a[LW-1], {(SAMPLE_BITS-1){~a[LW-1]}}};
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_state(
		input logic signed [LW-1:0] a
	);
		logic same;
		same = (&a[LW-1:STATE_BITS-1]) | ~(|a[LW-1:STATE_BITS-1]);
		if (same) begin
			return a[STATE_BITS-1:0];
		end
		return {a[LW-1], {(STATE_BITS-1){~a[LW-1]}}};
	endfunction

	assign hi_ext  = $signed({{(LW-DATA_BITS){hi[DATA_BITS-1]}}, hi});
	assign s_ext   = $signed({{(LW-STATE_BITS){s[STATE_BITS-1]}}, s});
	assign x_ext   = $signed({{(LW-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x});
	assign rnd_ext = $signed({{(LW-1){1'b0}}, rnd});

	always_ff @(posedge clk) begin
		if (capture) begin
			v_q   <= hi_ext + rnd_ext;
			low_q <= hi_ext + s_ext + rnd_ext;
		end
	end

	assign st_sum  = low_q + v_q;
	assign hp_diff = x_ext - low_q;

	assign state_next = sat_state(st_sum);
	assign y          = is_lowpass ? sat_sample(low_q) : sat_sample(hp_diff);

endmodule

// File: design/one_pole_highpass_lowpass_cascade_top.sv
// ----------------------------------------------------------------------------
// one_pole_highpass_lowpass_cascade_top - TPT high-pass then low-pass cascade
// Two one-pole trapezoidal sections sharing one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel sample_in_valid / sample_in_stall / sample_in moves one
//   signed sample per beat; output channel sample_out_valid /
//   sample_out_stall / sample_out returns one saturated sample per input beat.
//   The block takes one beat at a time. Each enabled section runs in order:
//   ST_PICK loads x - state into the multiplier, ST_MUL runs the shift-add
//   multiplier (one coefficient bit per cycle), then ST_FIN1 and ST_FIN2
//   update the integrator and saturate. A disabled section is skipped in
//   ST_PICK. After the low-pass slot the result goes out in ST_OUT.
//   The result sits in an output register, so the next beat is accepted
//   while the previous result waits; if the receiver still stalls when the
//   next result is ready, the sequencer holds it until the register frees.
//   Config writes (index, data, write strobe) must go in only while idle;
//   the block does not enforce it. Writing an enable register clears that
//   section's integrator. Reset clears config, sequencer, integrators, out valid.
// ----------------------------------------------------------------------------
module one_pole_highpass_lowpass_cascade_top #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_in_valid,
	output logic                                  sample_in_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample_in,
	output logic                                  sample_out_valid,
	input  logic                                  sample_out_stall,
	output logic signed [SAMPLE_BITS-1:0]         sample_out,
	input  logic                                  cfg_write,
	input  logic [opf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [COEF_BITS-1:0]                  cfg_data
);
	import opf_pkg::*;

	localparam int STATE_BITS = SAMPLE_BITS + STATE_HEADROOM;
	// x - state needs one bit over the state width
	localparam int DATA_BITS  = STATE_BITS + 1;

	// configuration
	logic                  lc_en_q;
	logic [COEF_BITS-1:0]  lc_coef_q;
	logic                  hc_en_q;
	logic [COEF_BITS-1:0]  hc_coef_q;

	// integrators
	logic signed [STATE_BITS-1:0]  hp_state_q;
	logic signed [STATE_BITS-1:0]  lp_state_q;

	// sequencer and working sample
	state_t                        state_q;
	state_t                        state_d;
	logic                          sec_q;   // 0: high-pass section, 1: low-pass
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;

	// section selection
	logic                          en_sel;
	logic [COEF_BITS-1:0]          coef_sel;
	logic signed [STATE_BITS-1:0]  s_sel;
	logic signed [DATA_BITS-1:0]   d_sel;

	// datapath control
	mul_ctl_t                      mul_ctl;
	logic                          tail_cap;
	logic                          out_load;
	logic                          in_accept;

	logic signed [DATA_BITS-1:0]   mul_hi;
	logic                          mul_rnd;
	logic                          mul_last;
	logic signed [STATE_BITS-1:0]  st_next;
	logic signed [SAMPLE_BITS-1:0] sec_y;

	assign en_sel   = sec_q ? hc_en_q : lc_en_q;
	assign coef_sel = sec_q ? hc_coef_q : lc_coef_q;
	assign s_sel    = sec_q ? lp_state_q : hp_state_q;
	assign d_sel    = $signed({{(DATA_BITS-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q})
		- $signed({s_sel[STATE_BITS-1], s_sel});

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				// skip a disabled section; leave after the low-pass slot
				priority if (en_sel) begin
					state_d = ST_MUL;
				end else if (sec_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PICK;
				end
			end
			ST_MUL: begin
				if (mul_last) begin
					state_d = ST_FIN1;
				end
			end
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = sec_q ? ST_OUT : ST_PICK;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer outputs ----
	always_comb begin
		sample_in_stall = (state_q != ST_IDLE);
		mul_ctl.load    = (state_q == ST_PICK) && en_sel;
		mul_ctl.step    = (state_q == ST_MUL);
		tail_cap        = (state_q == ST_FIN1);
		// hand the result over once the output register is free or emptying
		out_load        = (state_q == ST_OUT) && (!out_valid_q || !sample_out_stall);
	end

	assign in_accept = sample_in_valid && !sample_in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sec_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				sec_q <= 1'b0;
			end else if (!sec_q && (((state_q == ST_PICK) && !en_sel)
					|| (state_q == ST_FIN2))) begin
				sec_q <= 1'b1;
			end
		end
	end

	// ---- configuration and integrators ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_en_q    <= 1'b0;
			lc_coef_q  <= '0;
			hc_en_q    <= 1'b0;
			hc_coef_q  <= '0;
			hp_state_q <= '0;
			lp_state_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LOW_CUT_ENABLE: begin
					lc_en_q    <= cfg_data[0];
					hp_state_q <= '0;
				end
				REG_LOW_CUT_COEF:    lc_coef_q <= cfg_data;
				REG_HIGH_CUT_ENABLE: begin
					hc_en_q    <= cfg_data[0];
					lp_state_q <= '0;
				end
				REG_HIGH_CUT_COEF:   hc_coef_q <= cfg_data;
				default: ;
			endcase
		end else if (state_q == ST_FIN2) begin
			if (sec_q) begin
				lp_state_q <= st_next;
			end else begin
				hp_state_q <= st_next;
			end
		end
	end

	// ---- working sample ----
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q <= sample_in;
		end else if (state_q == ST_FIN2) begin
			x_q <= sec_y;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!sample_out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= x_q;
		end
	end

	assign sample_out_valid = out_valid_q;
	assign sample_out       = sample_out_q;

	opf_sermul #(
		.DATA_BITS (DATA_BITS),
		.COEF_BITS (COEF_BITS)
	) u_sermul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.d_in    (d_sel),
		.coef_in (coef_sel),
		.hi      (mul_hi),
		.rnd     (mul_rnd),
		.last    (mul_last)
	);

	opf_tail #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.STATE_BITS  (STATE_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_tail (
		.clk        (clk),
		.capture    (tail_cap),
		.is_lowpass (sec_q),
		.hi         (mul_hi),
		.rnd        (mul_rnd),
		.s          (s_sel),
		.x          (x_q),
		.state_next (st_next),
		.y          (sec_y)
	);

	// ---- assertions ----
	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == ST_PICK) && !sec_q)
		else $error("accepted beat did not start at the high-pass slot");

	a_mul_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && mul_last |=> (state_q == ST_FIN1))
		else $error("multiplier finish not followed by integrator update");

	a_lowpass_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN2) && sec_q |=> (state_q == ST_OUT))
		else $error("low-pass update not followed by result hand-over");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && out_valid_q && sample_out_stall |=> (state_q == ST_OUT))
		else $error("pending output overwritten");

endmodule
